@@ sv/multi_pattern_dfa_matcher_macros.svh @@
// ----------------------------------------------------------------------------
// Assertion macros for the multi-pattern DFA matcher
// Same-cycle and next-cycle implication checks; empty when SYNTH is set.
// ----------------------------------------------------------------------------
`ifndef MULTI_PATTERN_DFA_MATCHER_MACROS_SVH
`define MULTI_PATTERN_DFA_MATCHER_MACROS_SVH

`ifndef SYNTH
// antecedent implies consequent in the same cycle
`define MPDM_ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("mpdm: same-cycle check failed");
// antecedent implies consequent in the next cycle
`define MPDM_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("mpdm: next-cycle check failed");
`else
`define MPDM_ASSERT_SAME(label, clk, rst, ante, cons)
`define MPDM_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif

`endif

@@ sv/mpdm_pkg.sv @@
// ----------------------------------------------------------------------------
// mpdm_pkg
// Shared codes, field widths and helpers for the DFA matcher.
// ----------------------------------------------------------------------------
package mpdm_pkg;

   // port field widths
   localparam int MODE_W        = 2;
   localparam int BYTE_W        = 8;
   localparam int STATE_FIELD_W = 10;
   localparam int STATE_FIELD_MAX = (1 << STATE_FIELD_W) - 1;

   // input mode codes
   localparam logic [MODE_W-1:0] MODE_SCAN  = 2'd0;
   localparam logic [MODE_W-1:0] MODE_TRANS = 2'd1;
   localparam logic [MODE_W-1:0] MODE_MARK  = 2'd2;

   // ASCII case folding
   localparam logic [BYTE_W-1:0] ASCII_UPPER_A     = 8'h41;
   localparam logic [BYTE_W-1:0] ASCII_UPPER_Z     = 8'h5A;
   localparam logic [BYTE_W-1:0] ASCII_CASE_OFFSET = 8'h20;

   // command queue between front and back
   localparam int Q_DEPTH = 2;
   localparam int Q_PTR_W = $clog2(Q_DEPTH);
   localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

   // operation carried through the queue
   typedef enum logic [1:0] {
      OP_SCAN  = 2'd0,
      OP_TRANS = 2'd1,
      OP_MARK  = 2'd2
   } cmd_op_type;

   // remainder of a narrow field by a constant modulus, by shifted
   // compare-and-subtract steps (constant modulus folds at synthesis)
   function automatic logic [STATE_FIELD_W-1:0] reduce_mod(
      input logic [STATE_FIELD_W-1:0] value,
      input int unsigned              modulus
   );
      logic [STATE_FIELD_W-1:0] rem;
      int unsigned              step;
      rem = value;
      for (int i = STATE_FIELD_W - 1; i >= 0; i--) begin
         step = modulus << i;
         if (step <= STATE_FIELD_MAX && rem >= step) begin
            rem = rem - STATE_FIELD_W'(step);
         end
      end
      return rem;
   endfunction

endpackage

@@ sv/mpdm_intf.sv @@
// ----------------------------------------------------------------------------
// mpdm channel interfaces
// Request, response and register-write channels with valid/ready.
// ----------------------------------------------------------------------------

// request channel: scan bytes and table writes
interface mpdm_req_if import mpdm_pkg::*;;
   logic                     valid;
   logic                     ready;
   logic [MODE_W-1:0]        mode;
   logic [BYTE_W-1:0]        text_byte;
   logic                     end_of_text;
   logic [STATE_FIELD_W-1:0] entry_state;
   logic [STATE_FIELD_W-1:0] target_state;
   logic                     mark_value;

   modport source (
      output valid, mode, text_byte, end_of_text, entry_state, target_state, mark_value,
      input  ready
   );
   modport sink (
      input  valid, mode, text_byte, end_of_text, entry_state, target_state, mark_value,
      output ready
   );
endinterface

// response channel: one item per scanned byte
interface mpdm_rsp_if;
   logic valid;
   logic ready;
   logic hit;
   logic found;
   logic text_done;

   modport source (output valid, hit, found, text_done, input ready);
   modport sink   (input valid, hit, found, text_done, output ready);
endinterface

// register write channel
interface mpdm_csr_if;
   logic valid;
   logic ready;
   logic case_fold;

   modport source (output valid, case_fold, input ready);
   modport sink   (input valid, case_fold, output ready);
endinterface

@@ sv/mpdm_ram.sv @@
// ----------------------------------------------------------------------------
// mpdm_ram
// Generic simple dual-port RAM, registered read, read-old on collision.
// ----------------------------------------------------------------------------
module mpdm_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic                     re,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   // read returns the contents before a same-cycle write
   always_ff @(posedge clock) begin
      if (re) begin
         rdata_ff <= mem[raddr];
      end
      if (we) begin
         mem[waddr] <= wdata;
      end
   end

   assign rdata = rdata_ff;

endmodule

@@ sv/mpdm_front.sv @@
// ----------------------------------------------------------------------------
// mpdm_front
// Accepts items, folds and reduces fields, queues commands for the back end.
// ----------------------------------------------------------------------------
module mpdm_front import mpdm_pkg::*; #(
   parameter int NUM_STATES = 1024,
   parameter int ALPHABET   = 256
) (
   input  logic                          clock,
   input  logic                          reset,
   mpdm_req_if.sink                      req_if,
   mpdm_csr_if.sink                      csr_if,
   output logic                          cmd_valid,
   input  logic                          cmd_ready,
   output cmd_op_type                    cmd_op,
   output logic                          cmd_eot,
   output logic                          cmd_mark,
   output logic [$clog2(ALPHABET)-1:0]   cmd_sym,
   output logic [$clog2(NUM_STATES)-1:0] cmd_es,
   output logic [$clog2(NUM_STATES)-1:0] cmd_ts
);

   localparam int SW = $clog2(NUM_STATES);
   localparam int AW = $clog2(ALPHABET);

   logic                case_fold_ff, case_fold_in;
   logic                keep;
   cmd_op_type          op;
   logic [BYTE_W-1:0]   byte_sel;
   logic [AW-1:0]       sym;
   logic [SW-1:0]       es_red;
   logic [SW-1:0]       ts_red;
   logic                push;
   logic                pop;

   logic [Q_PTR_W-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [Q_PTR_W-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [Q_CNT_W-1:0]  count_ff, count_in;

   cmd_op_type          q_op_ff   [Q_DEPTH];
   logic                q_eot_ff  [Q_DEPTH];
   logic                q_mark_ff [Q_DEPTH];
   logic [AW-1:0]       q_sym_ff  [Q_DEPTH];
   logic [SW-1:0]       q_es_ff   [Q_DEPTH];
   logic [SW-1:0]       q_ts_ff   [Q_DEPTH];

   // case-fold register, always writable
   assign csr_if.ready = 1'b1;

   always_comb begin
      case_fold_in = case_fold_ff;
      if (csr_if.valid) begin
         case_fold_in = csr_if.case_fold;
      end
   end

   // classify the mode; unused mode is dropped
   always_comb begin
      keep = 1'b1;
      op   = OP_SCAN;
      case (req_if.mode)
         MODE_SCAN:  op = OP_SCAN;
         MODE_TRANS: op = OP_TRANS;
         MODE_MARK:  op = OP_MARK;
         default:    keep = 1'b0;
      endcase
   end

   // scan bytes fold to lower case when enabled; written symbols do not
   always_comb begin
      byte_sel = req_if.text_byte;
      if (op == OP_SCAN && case_fold_ff &&
          (req_if.text_byte inside {[ASCII_UPPER_A:ASCII_UPPER_Z]})) begin
         byte_sel = req_if.text_byte + ASCII_CASE_OFFSET;
      end
   end

   // reduce symbol and states into table range
   assign sym    = AW'(reduce_mod({2'b00, byte_sel}, ALPHABET));
   assign es_red = SW'(reduce_mod(req_if.entry_state, NUM_STATES));
   assign ts_red = SW'(reduce_mod(req_if.target_state, NUM_STATES));

   // queue control
   assign req_if.ready = (count_ff != Q_CNT_W'(Q_DEPTH));
   assign push         = req_if.valid && req_if.ready && keep;
   assign cmd_valid    = (count_ff != '0);
   assign pop          = cmd_valid && cmd_ready;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = rd_ptr_ff + 1'b1;
      end
      case ({push, pop})
         2'b10:   count_in = count_ff + 1'b1;
         2'b01:   count_in = count_ff - 1'b1;
         default: count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         case_fold_ff <= 1'b0;
         wr_ptr_ff    <= '0;
         rd_ptr_ff    <= '0;
         count_ff     <= '0;
      end else begin
         case_fold_ff <= case_fold_in;
         wr_ptr_ff    <= wr_ptr_in;
         rd_ptr_ff    <= rd_ptr_in;
         count_ff     <= count_in;
      end
   end

   // queue payload
   always_ff @(posedge clock) begin
      if (push) begin
         q_op_ff[wr_ptr_ff]   <= op;
         q_eot_ff[wr_ptr_ff]  <= req_if.end_of_text;
         q_mark_ff[wr_ptr_ff] <= req_if.mark_value;
         q_sym_ff[wr_ptr_ff]  <= sym;
         q_es_ff[wr_ptr_ff]   <= es_red;
         q_ts_ff[wr_ptr_ff]   <= ts_red;
      end
   end

   assign cmd_op   = q_op_ff[rd_ptr_ff];
   assign cmd_eot  = q_eot_ff[rd_ptr_ff];
   assign cmd_mark = q_mark_ff[rd_ptr_ff];
   assign cmd_sym  = q_sym_ff[rd_ptr_ff];
   assign cmd_es   = q_es_ff[rd_ptr_ff];
   assign cmd_ts   = q_ts_ff[rd_ptr_ff];

endmodule

@@ sv/mpdm_back.sv @@
// ----------------------------------------------------------------------------
// mpdm_back
// Executes queued commands: table writes, state walk, match lookup, result.
// ----------------------------------------------------------------------------
module mpdm_back import mpdm_pkg::*; #(
   parameter int NUM_STATES = 1024,
   parameter int ALPHABET   = 256
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          cmd_valid,
   output logic                          cmd_ready,
   input  cmd_op_type                    cmd_op,
   input  logic                          cmd_eot,
   input  logic                          cmd_mark,
   input  logic [$clog2(ALPHABET)-1:0]   cmd_sym,
   input  logic [$clog2(NUM_STATES)-1:0] cmd_es,
   input  logic [$clog2(NUM_STATES)-1:0] cmd_ts,
   mpdm_rsp_if.source                    rsp_if
);

   localparam int SW      = $clog2(NUM_STATES);
   localparam int AW      = $clog2(ALPHABET);
   localparam int TADDR_W = SW + AW;

   logic               adv;
   logic               pop;
   logic               tbl_we, tbl_re;
   logic               mark_we, mark_re;
   logic [TADDR_W-1:0] tbl_waddr, tbl_raddr;
   logic [SW-1:0]      tbl_rdata;
   logic               mark_rdata;
   logic [SW-1:0]      fwd_state;
   logic [SW-1:0]      scan_state;
   logic               found_now;

   logic               s1_valid_ff, s1_valid_in;
   logic               s1_eot_ff, s1_eot_in;
   logic               s2_valid_ff, s2_valid_in;
   logic               s2_eot_ff, s2_eot_in;
   logic [SW-1:0]      cur_state_ff, cur_state_in;
   logic               found_ff, found_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic               rsp_hit_ff, rsp_hit_in;
   logic               rsp_found_ff, rsp_found_in;
   logic               rsp_done_ff, rsp_done_in;

   // whole back end moves when the result slot is free
   assign adv       = !rsp_valid_ff || rsp_if.ready;
   assign cmd_ready = adv;
   assign pop       = cmd_valid && adv;

   // command decode
   assign tbl_we  = pop && (cmd_op == OP_TRANS);
   assign mark_we = pop && (cmd_op == OP_MARK);
   assign tbl_re  = pop && (cmd_op == OP_SCAN);
   assign mark_re = adv && s1_valid_ff;

   // next state of the scan in flight, back to root after its last byte
   assign fwd_state  = s1_eot_ff ? '0 : tbl_rdata;
   assign scan_state = s1_valid_ff ? fwd_state : cur_state_ff;

   assign tbl_waddr = {cmd_es, cmd_sym};
   assign tbl_raddr = {scan_state, cmd_sym};

   mpdm_ram #(
      .WIDTH (SW),
      .DEPTH (2 ** TADDR_W)
   ) u_trans_ram (
      .clock (clock),
      .we    (tbl_we),
      .waddr (tbl_waddr),
      .wdata (cmd_ts),
      .re    (tbl_re),
      .raddr (tbl_raddr),
      .rdata (tbl_rdata)
   );

   mpdm_ram #(
      .WIDTH (1),
      .DEPTH (NUM_STATES)
   ) u_mark_ram (
      .clock (clock),
      .we    (mark_we),
      .waddr (cmd_es),
      .wdata (cmd_mark),
      .re    (mark_re),
      .raddr (tbl_rdata),
      .rdata (mark_rdata)
   );

   assign found_now = found_ff | mark_rdata;

   // pipeline advance: table read, mark read, result register
   always_comb begin
      s1_valid_in  = s1_valid_ff;
      s1_eot_in    = s1_eot_ff;
      s2_valid_in  = s2_valid_ff;
      s2_eot_in    = s2_eot_ff;
      cur_state_in = cur_state_ff;
      found_in     = found_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_hit_in   = rsp_hit_ff;
      rsp_found_in = rsp_found_ff;
      rsp_done_in  = rsp_done_ff;
      if (adv) begin
         s1_valid_in = tbl_re;
         if (tbl_re) begin
            s1_eot_in = cmd_eot;
         end
         s2_valid_in = s1_valid_ff;
         if (s1_valid_ff) begin
            s2_eot_in    = s1_eot_ff;
            cur_state_in = fwd_state;
         end
         rsp_valid_in = s2_valid_ff;
         if (s2_valid_ff) begin
            rsp_hit_in   = mark_rdata;
            rsp_found_in = found_now;
            rsp_done_in  = s2_eot_ff;
            found_in     = s2_eot_ff ? 1'b0 : found_now;
         end
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         s2_valid_ff  <= 1'b0;
         cur_state_ff <= '0;
         found_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         s2_valid_ff  <= s2_valid_in;
         cur_state_ff <= cur_state_in;
         found_ff     <= found_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      s1_eot_ff    <= s1_eot_in;
      s2_eot_ff    <= s2_eot_in;
      rsp_hit_ff   <= rsp_hit_in;
      rsp_found_ff <= rsp_found_in;
      rsp_done_ff  <= rsp_done_in;
   end

   assign rsp_if.valid     = rsp_valid_ff;
   assign rsp_if.hit       = rsp_hit_ff;
   assign rsp_if.found     = rsp_found_ff;
   assign rsp_if.text_done = rsp_done_ff;

endmodule

@@ sv/multi_pattern_dfa_matcher.sv @@
// Scan path: queue, table read, mark read, result. Throughput: one item per
// cycle while responses are taken; the next-state table read feeds the next
// byte's lookup address directly, so scans and writes issue back to back.
// Reset clears the walk state, found flag, case-fold register and queues;
// transition and match tables are undefined until written (no clear pass).
// ----------------------------------------------------------------------------
// multi_pattern_dfa_matcher
// Aho-Corasick style scanner over a complete transition table: front end
// classifies items, back end walks the table and reports matches.
// ----------------------------------------------------------------------------
`include "multi_pattern_dfa_matcher_macros.svh"

module multi_pattern_dfa_matcher import mpdm_pkg::*; #(
   parameter int NUM_STATES = 1024,
   parameter int ALPHABET   = 256
) (
   input  logic       clock,
   input  logic       reset,
   mpdm_req_if.sink   req_if,
   mpdm_rsp_if.source rsp_if,
   mpdm_csr_if.sink   csr_if
);

   localparam int SW = $clog2(NUM_STATES);
   localparam int AW = $clog2(ALPHABET);

   logic          cmd_valid;
   logic          cmd_ready;
   cmd_op_type    cmd_op;
   logic          cmd_eot;
   logic          cmd_mark;
   logic [AW-1:0] cmd_sym;
   logic [SW-1:0] cmd_es;
   logic [SW-1:0] cmd_ts;

   // accept and classify
   mpdm_front #(
      .NUM_STATES (NUM_STATES),
      .ALPHABET   (ALPHABET)
   ) u_front (
      .clock     (clock),
      .reset     (reset),
      .req_if    (req_if),
      .csr_if    (csr_if),
      .cmd_valid (cmd_valid),
      .cmd_ready (cmd_ready),
      .cmd_op    (cmd_op),
      .cmd_eot   (cmd_eot),
      .cmd_mark  (cmd_mark),
      .cmd_sym   (cmd_sym),
      .cmd_es    (cmd_es),
      .cmd_ts    (cmd_ts)
   );

   // execute
   mpdm_back #(
      .NUM_STATES (NUM_STATES),
      .ALPHABET   (ALPHABET)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .cmd_valid (cmd_valid),
      .cmd_ready (cmd_ready),
      .cmd_op    (cmd_op),
      .cmd_eot   (cmd_eot),
      .cmd_mark  (cmd_mark),
      .cmd_sym   (cmd_sym),
      .cmd_es    (cmd_es),
      .cmd_ts    (cmd_ts),
      .rsp_if    (rsp_if)
   );

   // a hit always sets found for the same item
   `MPDM_ASSERT_SAME(a_hit_sets_found, clock, reset, rsp_if.valid && rsp_if.hit, rsp_if.found)
   // input stalls only when the queue is full, so the back end has work
   `MPDM_ASSERT_SAME(a_stall_means_work, clock, reset, !req_if.ready, cmd_valid)
   // a queued command is not dropped while the back end stalls
   `MPDM_ASSERT_NEXT(a_cmd_held, clock, reset, cmd_valid && !cmd_ready, cmd_valid)

endmodule

@@ sim/multi_pattern_dfa_matcher_tb.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// multi_pattern_dfa_matcher_tb
// The bench loads a small DFA through the request channel and then
// scans text through it. It starts with a fixed table of rows that gives the
// expected results directly. Random texts follow, with table rewrites and
// unused-mode noise mixed in, under several handshake idling patterns and a
// long response hold-off. A DFA walker predicts every random-text response.
// ----------------------------------------------------------------------------
module multi_pattern_dfa_matcher_tb import mpdm_pkg::*;;

   localparam int CLK_HALF       = 5;
   localparam int RESET_CYCLES   = 10;
   localparam int SETTLE_CYCLES  = 8;
   localparam int CYCLE_LIMIT    = 400000;
   localparam int RSP_HOLD_CYCLES = 160;
   localparam int POOL_SIZE      = 8;
   localparam int DIR_ROWS       = 27;

   localparam logic [MODE_W-1:0]        MODE_UNUSED = 2'd3;
   localparam logic [STATE_FIELD_W-1:0] ST_TOP      = STATE_FIELD_MAX;
   localparam logic [BYTE_W-1:0]        CH_UPPER_A  = ASCII_UPPER_A;
   localparam logic [BYTE_W-1:0]        CH_LOWER_A  = ASCII_UPPER_A + ASCII_CASE_OFFSET;
   localparam logic [BYTE_W-1:0]        CH_UPPER_Z  = ASCII_UPPER_Z;
   localparam logic [BYTE_W-1:0]        CH_LOWER_Z  = ASCII_UPPER_Z + ASCII_CASE_OFFSET;

   // bytes every pooled state gets a transition for before random scanning
   localparam logic [BYTE_W-1:0] SEED_BYTES [8] = '{8'h00, 8'hFF, CH_LOWER_A, CH_LOWER_Z,
                                                    CH_UPPER_A, CH_UPPER_Z, 8'h55, 8'hAA};

   // one request item, 32 bits in all
   typedef struct packed {
      logic [MODE_W-1:0]        mode;
      logic [BYTE_W-1:0]        text_byte;
      logic                     end_of_text;
      logic [STATE_FIELD_W-1:0] entry_state;
      logic [STATE_FIELD_W-1:0] target_state;
      logic                     mark_value;
   } scan_req_type;

   typedef struct packed {
      logic hit;
      logic found;
      logic text_done;
   } scan_rsp_type;

   typedef enum logic {ROW_ITEM, ROW_CFG} row_kind_type;

   typedef struct {
      row_kind_type             kind;
      logic [MODE_W-1:0]        mode;
      logic [BYTE_W-1:0]        text_byte;
      logic                     end_of_text;
      logic [STATE_FIELD_W-1:0] entry_state;
      logic [STATE_FIELD_W-1:0] target_state;
      logic                     mark_value;
      logic                     fold_value;
      bit                       typed;
      logic                     hit;
      logic                     found;
      logic                     text_done;
   } dir_row_type;

   // directed rows: a two-state DFA (root and top state), then scans
   dir_row_type directed_rows [DIR_ROWS] = '{
      '{ROW_ITEM, MODE_MARK,   8'h00,      0, 10'd0,  10'd0,  0, 0, 0, 0, 0, 0},
      '{ROW_ITEM, MODE_MARK,   8'h00,      0, ST_TOP, 10'd0,  1, 0, 0, 0, 0, 0},
      '{ROW_ITEM, MODE_TRANS,  8'h00,      0, 10'd0,  10'd0,  0, 0, 0, 0, 0, 0},
      '{ROW_ITEM, MODE_TRANS,  8'hFF,      0, 10'd0,  ST_TOP, 0, 0, 0, 0, 0, 0},
      '{ROW_ITEM, MODE_TRANS,  8'h00,      0, ST_TOP, 10'd0,  0, 0, 0, 0, 0, 0},
      '{ROW_ITEM, MODE_TRANS,  8'hFF,      0, ST_TOP, ST_TOP, 0, 0, 0, 0, 0, 0},
      '{ROW_ITEM, MODE_TRANS,  CH_LOWER_A, 0, 10'd0,  ST_TOP, 0, 0, 0, 0, 0, 0},
      '{ROW_ITEM, MODE_TRANS,  CH_UPPER_A, 0, 10'd0,  10'd0,  0, 0, 0, 0, 0, 0},
      '{ROW_ITEM, MODE_TRANS,  CH_LOWER_A, 0, ST_TOP, 10'd0,  0, 0, 0, 0, 0, 0},
      '{ROW_ITEM, MODE_TRANS,  CH_UPPER_A, 0, ST_TOP, ST_TOP, 0, 0, 0, 0, 0, 0},
      // unused mode with every field high: no response, no state change
      '{ROW_ITEM, MODE_UNUSED, 8'hFF,      1, ST_TOP, ST_TOP, 1, 0, 0, 0, 0, 0},
      // plain scans, no folding; found is sticky until end of text
      '{ROW_ITEM, MODE_SCAN,   8'h00,      0, ST_TOP, ST_TOP, 1, 0, 1, 0, 0, 0},
      '{ROW_ITEM, MODE_SCAN,   8'hFF,      0, 10'd0,  10'd0,  0, 0, 1, 1, 1, 0},
      '{ROW_ITEM, MODE_SCAN,   8'h00,      0, ST_TOP, 10'd0,  1, 0, 1, 0, 1, 0},
      '{ROW_ITEM, MODE_SCAN,   8'h00,      1, 10'd0,  ST_TOP, 0, 0, 1, 0, 1, 1},
      '{ROW_ITEM, MODE_SCAN,   8'h00,      1, ST_TOP, ST_TOP, 1, 0, 1, 0, 0, 1},
      '{ROW_ITEM, MODE_SCAN,   CH_UPPER_A, 0, 10'd0,  10'd0,  0, 0, 1, 0, 0, 0},
      '{ROW_ITEM, MODE_SCAN,   8'hFF,      1, 10'd0,  10'd0,  1, 0, 1, 1, 1, 1},
      // case folding on: upper-case text uses the lower-case entries
      '{ROW_CFG,  MODE_SCAN,   8'h00,      0, 10'd0,  10'd0,  0, 1, 0, 0, 0, 0},
      '{ROW_ITEM, MODE_SCAN,   CH_UPPER_A, 0, 10'd0,  10'd0,  0, 0, 1, 1, 1, 0},
      '{ROW_ITEM, MODE_SCAN,   CH_UPPER_A, 0, ST_TOP, ST_TOP, 1, 0, 1, 0, 1, 0},
      '{ROW_ITEM, MODE_SCAN,   CH_LOWER_A, 1, 10'd0,  10'd0,  0, 0, 1, 1, 1, 1},
      // mark rewritten mid-text; the walk position is kept across writes
      '{ROW_ITEM, MODE_MARK,   8'hFF,      1, ST_TOP, 10'd0,  0, 0, 0, 0, 0, 0},
      '{ROW_ITEM, MODE_SCAN,   8'hFF,      0, 10'd0,  10'd0,  0, 0, 1, 0, 0, 0},
      '{ROW_ITEM, MODE_MARK,   8'h00,      0, ST_TOP, ST_TOP, 1, 0, 0, 0, 0, 0},
      '{ROW_ITEM, MODE_SCAN,   CH_UPPER_A, 1, 10'd0,  10'd0,  0, 0, 1, 0, 0, 1},
      '{ROW_CFG,  MODE_SCAN,   8'h00,      0, 10'd0,  10'd0,  0, 0, 0, 0, 0, 0}
   };

   logic clock;
   logic reset;

   mpdm_req_if req_bus ();
   mpdm_rsp_if rsp_bus ();
   mpdm_csr_if csr_bus ();

   multi_pattern_dfa_matcher dut (
      .clock  (clock),
      .reset  (reset),
      .req_if (req_bus),
      .rsp_if (rsp_bus),
      .csr_if (csr_bus)
   );

   // predicted DFA contents and walk position
   logic [STATE_FIELD_W-1:0] next_of [int];
   logic                     marked [int];
   logic [STATE_FIELD_W-1:0] walk_state;
   logic                     found_sticky;
   logic                     fold_on;

   scan_rsp_type pending_results [$];

   // states the random texts walk through; transitions out of them stay inside
   logic [STATE_FIELD_W-1:0] pool_states [POOL_SIZE];
   bit                       in_pool [int];

   int send_idle_pct;
   int recv_stall_pct;
   int hold_asks;
   int mismatch_count;
   int cycle_count;

   // clock
   initial begin
      clock = 1'b0;
      forever #CLK_HALF clock = ~clock;
   end

   // run limit
   initial cycle_count = 0;
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("[FAIL] regression broken");
         $finish;
      end
   end

   function automatic logic [BYTE_W-1:0] fold_case(input logic [BYTE_W-1:0] b);
      if (fold_on && b >= ASCII_UPPER_A && b <= ASCII_UPPER_Z) return b + ASCII_CASE_OFFSET;
      return b;
   endfunction

   // true when the lookup from st on sym hits written table entry and mark
   function automatic bit walk_defined(input logic [STATE_FIELD_W-1:0] st,
                                       input logic [BYTE_W-1:0] sym);
      int key;
      key = int'({st, sym});
      if (!next_of.exists(key)) return 1'b0;
      return marked.exists(int'(next_of[key]));
   endfunction

   // advance the DFA by one accepted item; returns 1 when a response is due
   function automatic bit dfa_step(input scan_req_type it, output scan_rsp_type res);
      int                       key;
      logic [STATE_FIELD_W-1:0] nxt;
      res = '0;
      case (it.mode)
         MODE_TRANS: begin
            next_of[int'({it.entry_state, it.text_byte})] = it.target_state;
            return 1'b0;
         end
         MODE_MARK: begin
            marked[int'(it.entry_state)] = it.mark_value;
            return 1'b0;
         end
         MODE_SCAN: ;
         default: return 1'b0;
      endcase
      key = int'({walk_state, fold_case(it.text_byte)});
      nxt = next_of.exists(key) ? next_of[key] : '0;
      res.hit = marked.exists(int'(nxt)) ? marked[int'(nxt)] : 1'b0;
      found_sticky = found_sticky | res.hit;
      res.found = found_sticky;
      res.text_done = it.end_of_text;
      walk_state = nxt;
      if (it.end_of_text) begin
         walk_state = '0;
         found_sticky = 1'b0;
      end
      return 1'b1;
   endfunction

   task automatic report_mismatch(input string what, input int got, input int want);
      mismatch_count++;
      $display("%0t mismatch: %s got %0d want %0d", $realtime, what, got, want);
   endtask

   // offer one item, wait for the handshake, then log its expected response
   task automatic offer_item(input scan_req_type it, input bit use_typed,
                             input scan_rsp_type typed_rsp);
      scan_rsp_type res;
      while ($urandom_range(99) < send_idle_pct) begin
         req_bus.valid <= 1'b0;
         @(posedge clock);
      end
      req_bus.valid        <= 1'b1;
      req_bus.mode         <= it.mode;
      req_bus.text_byte    <= it.text_byte;
      req_bus.end_of_text  <= it.end_of_text;
      req_bus.entry_state  <= it.entry_state;
      req_bus.target_state <= it.target_state;
      req_bus.mark_value   <= it.mark_value;
      @(posedge clock);
      while (req_bus.ready !== 1'b1) @(posedge clock);
      if (dfa_step(it, res)) pending_results.push_back(use_typed ? typed_rsp : res);
   endtask

   // stop offering until every response is in and the pipe has settled
   task automatic wait_drained();
      req_bus.valid <= 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_case_fold(input logic value);
      wait_drained();
      csr_bus.valid     <= 1'b1;
      csr_bus.case_fold <= value;
      @(posedge clock);
      while (csr_bus.ready !== 1'b1) @(posedge clock);
      csr_bus.valid <= 1'b0;
      fold_on = value;
   endtask

   // table rewrite or unused-mode noise; counted is 0 for noise
   task automatic send_side_item(output bit counted);
      scan_req_type it;
      int           pick;
      it = scan_req_type'($urandom);
      pick = $urandom_range(99);
      counted = 1'b1;
      if (pick < 15) begin
         it.mode = MODE_UNUSED;
         counted = 1'b0;
      end else begin
         if ($urandom_range(99) < 80) it.entry_state = pool_states[$urandom_range(POOL_SIZE-1)];
         if (pick < 60) begin
            it.mode = MODE_TRANS;
            if (in_pool.exists(int'(it.entry_state)))
               it.target_state = pool_states[$urandom_range(POOL_SIZE-1)];
            if ($urandom_range(2) == 0)
               it.text_byte = ($urandom_range(1) ? CH_LOWER_A : CH_UPPER_A)
                              + BYTE_W'($urandom_range(25));
         end else begin
            it.mode = MODE_MARK;
         end
      end
      offer_item(it, 1'b0, '0);
   endtask

   // scan one byte whose lookup is defined from the predicted state, or noise if none is
   task automatic send_scan_byte(input logic last, output bit counted);
      scan_req_type      it;
      logic [BYTE_W-1:0] legal [$];
      it = scan_req_type'($urandom);
      for (int v = 0; v < 256; v++) begin
         if (walk_defined(walk_state, fold_case(BYTE_W'(v)))) legal.push_back(BYTE_W'(v));
      end
      if (legal.size() == 0) begin
         it.mode = MODE_UNUSED;
         counted = 1'b0;
      end else begin
         it.mode = MODE_SCAN;
         it.text_byte = legal[$urandom_range(legal.size()-1)];
         it.end_of_text = last;
         counted = 1'b1;
      end
      offer_item(it, 1'b0, '0);
   endtask

   // random texts, mostly short, with writes and noise between bytes
   task automatic run_texts(input int budget);
      int sent;
      int text_len;
      bit counted;
      sent = 0;
      while (sent < budget) begin
         text_len = ($urandom_range(9) == 0) ? $urandom_range(12, 30) : $urandom_range(1, 8);
         for (int pos = 0; pos < text_len; pos++) begin
            while ($urandom_range(99) < 15) begin
               send_side_item(counted);
               sent += int'(counted);
            end
            send_scan_byte(pos == text_len - 1, counted);
            sent += int'(counted);
         end
      end
   endtask

   // response ready, with a counted hold-off on request
   initial begin
      int hold_left;
      int asks_seen;
      hold_left = 0;
      asks_seen = 0;
      rsp_bus.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (asks_seen != hold_asks) begin
            asks_seen = hold_asks;
            hold_left = RSP_HOLD_CYCLES;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_bus.ready <= 1'b0;
         end else begin
            rsp_bus.ready <= ($urandom_range(99) >= recv_stall_pct);
         end
      end
   end

   // response check against the oldest pending prediction
   always @(posedge clock) begin
      scan_rsp_type want;
      if (!reset && rsp_bus.valid === 1'b1 && rsp_bus.ready === 1'b1) begin
         if (pending_results.size() == 0) begin
            report_mismatch("response with nothing pending", 1, 0);
         end else begin
            want = pending_results.pop_front();
            if (rsp_bus.hit !== want.hit)
               report_mismatch("hit", int'(rsp_bus.hit), int'(want.hit));
            if (rsp_bus.found !== want.found)
               report_mismatch("found", int'(rsp_bus.found), int'(want.found));
            if (rsp_bus.text_done !== want.text_done)
               report_mismatch("text_done", int'(rsp_bus.text_done), int'(want.text_done));
         end
      end
   end

   // main sequence
   initial begin
      scan_req_type it;
      scan_rsp_type typed_rsp;
      int           cand;
      reset                <= 1'b1;
      req_bus.valid        <= 1'b0;
      req_bus.mode         <= MODE_SCAN;
      req_bus.text_byte    <= '0;
      req_bus.end_of_text  <= 1'b0;
      req_bus.entry_state  <= '0;
      req_bus.target_state <= '0;
      req_bus.mark_value   <= 1'b0;
      csr_bus.valid        <= 1'b0;
      csr_bus.case_fold    <= 1'b0;
      send_idle_pct  = 0;
      recv_stall_pct = 0;
      hold_asks      = 0;
      mismatch_count = 0;
      walk_state     = '0;
      found_sticky   = 1'b0;
      fold_on        = 1'b0;

      // pool: root, top, two alternating bit patterns, four random states
      pool_states[0] = '0;
      pool_states[1] = ST_TOP;
      pool_states[2] = 10'h155;
      pool_states[3] = 10'h2AA;
      for (int i = 0; i < 4; i++) begin
         in_pool[int'(pool_states[i])] = 1'b1;
      end
      for (int i = 4; i < POOL_SIZE; i++) begin
         cand = $urandom_range(1, STATE_FIELD_MAX - 1);
         while (in_pool.exists(cand)) cand = $urandom_range(1, STATE_FIELD_MAX - 1);
         pool_states[i] = STATE_FIELD_W'(cand);
         in_pool[cand] = 1'b1;
      end

      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed rows
      foreach (directed_rows[i]) begin
         if (directed_rows[i].kind == ROW_CFG) begin
            write_case_fold(directed_rows[i].fold_value);
         end else begin
            it.mode         = directed_rows[i].mode;
            it.text_byte    = directed_rows[i].text_byte;
            it.end_of_text  = directed_rows[i].end_of_text;
            it.entry_state  = directed_rows[i].entry_state;
            it.target_state = directed_rows[i].target_state;
            it.mark_value   = directed_rows[i].mark_value;
            typed_rsp.hit       = directed_rows[i].hit;
            typed_rsp.found     = directed_rows[i].found;
            typed_rsp.text_done = directed_rows[i].text_done;
            offer_item(it, directed_rows[i].typed, typed_rsp);
         end
      end

      // give every pooled state a mark and a base set of transitions
      for (int s = 0; s < POOL_SIZE; s++) begin
         it = scan_req_type'($urandom);
         it.mode = MODE_MARK;
         it.entry_state = pool_states[s];
         offer_item(it, 1'b0, '0);
         foreach (SEED_BYTES[b]) begin
            it = scan_req_type'($urandom);
            it.mode = MODE_TRANS;
            it.entry_state = pool_states[s];
            it.text_byte = SEED_BYTES[b];
            it.target_state = pool_states[$urandom_range(POOL_SIZE-1)];
            offer_item(it, 1'b0, '0);
         end
      end

      // random phases with different idling patterns
      run_texts(80);
      write_case_fold(1'b1);
      send_idle_pct = 82;
      run_texts(70);
      write_case_fold(1'b0);
      send_idle_pct  = 0;
      recv_stall_pct = 82;
      run_texts(70);
      write_case_fold(1'b1);
      send_idle_pct  = 23;
      recv_stall_pct = 23;
      run_texts(80);

      // back-pressure: long response hold while requests keep coming
      wait_drained();
      send_idle_pct  = 0;
      recv_stall_pct = 0;
      hold_asks++;
      run_texts(50);

      wait_drained();
      if (mismatch_count == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

endmodule
